// File: src/mvsr_pkg.sv
// ----------------------------------------------------------------------------
// mvsr_pkg
// Shared types and constants of the multi-voice sample recorder and player.
// ----------------------------------------------------------------------------
package mvsr_pkg;

  // Field widths fixed by the item formats.
  localparam int SMP_W      = 16;
  localparam int POS_W      = 17;
  localparam int RPOS_W     = 34;
  localparam int LVL_W      = 16;
  localparam int SPEED_W    = 20;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 15;
  localparam int START_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int REQ_W      = 3;
  localparam int VOICE_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Envelope level that means unity.
  localparam logic [LVL_W-1:0] ENV_ONE = 16'h8000;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START_REC  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP_REC   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START_PLAY = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP_PLAY  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_SPEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE_STEP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_START    = 2'd3;

  // One entry of the voice state memory.
  typedef struct packed {
    logic              recording;
    logic [POS_W-1:0]  wpos;
    logic [POS_W-1:0]  take_len;
    logic              has_take;
    logic              playing;
    logic              once_mode;
    logic              loop_mode;
    logic              fading_in;
    logic              fading_out;
    logic [LVL_W-1:0]  level;
    logic [RPOS_W-1:0] rpos;
  } voice_t;

  localparam voice_t VOICE_RESET = '{level: ENV_ONE, default: '0};

endpackage

// File: src/mvsr_if.sv
// ----------------------------------------------------------------------------
// mvsr_if
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mvsr_req_if;
  logic                               valid;
  logic                               ready;
  logic [mvsr_pkg::REQ_W-1:0]         req_type;
  logic [mvsr_pkg::VOICE_W-1:0]       voice;
  logic signed [mvsr_pkg::SMP_W-1:0]  in_sample;
  logic                               play_once;
  logic                               play_loop;

  modport source (output valid, req_type, voice, in_sample, play_once, play_loop,
                  input ready);
  modport sink (input valid, req_type, voice, in_sample, play_once, play_loop,
                output ready);
endinterface

interface mvsr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [mvsr_pkg::SMP_W-1:0]  mix_sample;
  logic                               voice_recording;
  logic                               voice_playing;

  modport source (output valid, mix_sample, voice_recording, voice_playing,
                  input ready);
  modport sink (input valid, mix_sample, voice_recording, voice_playing,
                output ready);
endinterface

// File: src/mvsr_voice_mem.sv
// ----------------------------------------------------------------------------
// mvsr_voice_mem
// Voice state memory with one write and one registered read port. Entries
// not yet written read as the reset state, tracked by per-entry valid bits.
// ----------------------------------------------------------------------------
module mvsr_voice_mem #(
  parameter int VOICES = 32,
  localparam int VA_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [VA_W-1:0]      rd_addr,
  output mvsr_pkg::voice_t     rd_data,
  input  logic                 wr_en,
  input  logic [VA_W-1:0]      wr_addr,
  input  mvsr_pkg::voice_t     wr_data
);

  mvsr_pkg::voice_t mem [VOICES];
  logic [VOICES-1:0] valid;
  mvsr_pkg::voice_t rd_q;
  logic             vld_q;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // Valid bits cleared by reset, set by the first write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_data = vld_q ? rd_q : mvsr_pkg::VOICE_RESET;

endmodule

// File: src/mvsr_sample_mem.sv
// ----------------------------------------------------------------------------
// mvsr_sample_mem
// Sample store for all voices: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mvsr_sample_mem #(
  parameter int DEPTH = 2097152,
  localparam int SA_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic [SA_W-1:0]             rd_addr,
  output logic [mvsr_pkg::SMP_W-1:0]  rd_data,
  input  logic                        wr_en,
  input  logic [SA_W-1:0]             wr_addr,
  input  logic [mvsr_pkg::SMP_W-1:0]  wr_data
);

  logic [mvsr_pkg::SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: src/mvsr_engine.sv
// ----------------------------------------------------------------------------
// mvsr_engine
// Sequencer that walks the voices through the state and sample memories,
// records, interpolates, scales and mixes, and holds the result register.
// ----------------------------------------------------------------------------
module mvsr_engine #(
  parameter int VOICES = 32,
  parameter int BUFFER_DEPTH = 65536,
  localparam int VA_W = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int SA_W = $clog2(VOICES * BUFFER_DEPTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  mvsr_req_if.sink                               in_ch,
  mvsr_rsp_if.source                             out_ch,
  input  logic signed [mvsr_pkg::SPEED_W-1:0]    play_speed,
  input  logic [mvsr_pkg::GAIN_W-1:0]            gain,
  input  logic [mvsr_pkg::STEP_W-1:0]            envelope_step,
  input  logic [mvsr_pkg::START_W-1:0]           play_start,
  output logic [VA_W-1:0]                        vm_rd_addr,
  input  mvsr_pkg::voice_t                       vm_rd_data,
  output logic                                   vm_wr_en,
  output logic [VA_W-1:0]                        vm_wr_addr,
  output mvsr_pkg::voice_t                       vm_wr_data,
  output logic [SA_W-1:0]                        sm_rd_addr,
  input  logic [mvsr_pkg::SMP_W-1:0]             sm_rd_data,
  output logic                                   sm_wr_en,
  output logic [SA_W-1:0]                        sm_wr_addr,
  output logic [mvsr_pkg::SMP_W-1:0]             sm_wr_data
);

  localparam int MIX_W = 24 + $clog2(VOICES) + 1;
  localparam logic [VA_W-1:0] LAST_VOICE = VA_W'(VOICES - 1);
  localparam logic [mvsr_pkg::POS_W-1:0] DEPTH_P = mvsr_pkg::POS_W'(BUFFER_DEPTH);
  localparam logic [SA_W-1:0] DEPTH_A = SA_W'(BUFFER_DEPTH);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ISSUE = 11'b00000000010,
    S_EVAL  = 11'b00000000100,
    S_RDA   = 11'b00000001000,
    S_RDB   = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_GAIN  = 11'b00001000000,
    S_ENV   = 11'b00010000000,
    S_WB    = 11'b00100000000,
    S_REQ   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state;

  // Latched item.
  logic [mvsr_pkg::REQ_W-1:0]   req_q;
  logic [mvsr_pkg::VOICE_W-1:0] voice_q;
  logic [mvsr_pkg::SMP_W-1:0]   sample_q;
  logic                         once_q;
  logic                         loop_q;
  logic                         vvalid_q;

  // Voice walk and datapath registers.
  logic [VA_W-1:0]              vidx;
  mvsr_pkg::voice_t             vs_q;
  logic [SA_W-1:0]              addr_a;
  logic [SA_W-1:0]              addr_b;
  logic                         ok_a;
  logic                         ok_b;
  logic [mvsr_pkg::FRAC_W-1:0]  frac_q;
  logic signed [15:0]           a_q;
  logic signed [33:0]           prod_q;
  logic signed [33:0]           g_q;
  logic signed [39:0]           e_q;
  logic signed [MIX_W-1:0]      mix_q;
  logic                         rep_rec;
  logic                         rep_play;

  // Result register.
  logic                         out_valid;
  logic signed [15:0]           out_mix;
  logic                         out_rec;
  logic                         out_play;

  logic                         in_fire;
  logic                         in_vvalid;
  logic                         is_mine;
  logic                         done_load;
  logic [SA_W-1:0]              base;

  // Head evaluation signals.
  logic signed [35:0]           h0;
  logic signed [35:0]           len_fx;
  logic signed [35:0]           start_fx;
  logic signed [35:0]           h1;
  logic signed [19:0]           idx;
  logic signed [19:0]           idx_b;
  logic signed [19:0]           len_s;
  logic                         wrap_hi;
  logic                         wrap_lo;
  logic [mvsr_pkg::RPOS_W-1:0]  h_new;
  logic [mvsr_pkg::POS_W-1:0]   wp1;
  mvsr_pkg::voice_t             rec_nv;
  mvsr_pkg::voice_t             req_nv;
  mvsr_pkg::voice_t             env_nv;
  mvsr_pkg::voice_t             play_nv;
  logic [mvsr_pkg::RPOS_W-1:0]  start34;

  // Arithmetic signals.
  logic signed [15:0]           b_val;
  logic signed [16:0]           diff;
  logic signed [33:0]           sh;
  logic signed [16:0]           interp;
  logic signed [21:0]           x_g;
  logic signed [17:0]           lvl_mul;
  logic [16:0]                  lvl_up;
  logic signed [17:0]           lvl_dn;
  logic signed [24:0]           voice_out;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign in_vvalid = (7'(in_ch.voice) < 7'(VOICES));
  assign is_mine   = vvalid_q && (VA_W'(voice_q) == vidx);
  assign base      = SA_W'(vidx) * DEPTH_A;
  assign done_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  assign out_ch.valid           = out_valid;
  assign out_ch.mix_sample      = out_mix;
  assign out_ch.voice_recording = out_rec;
  assign out_ch.voice_playing   = out_play;

  // Read head wrap and frame addresses for the voice just read.
  always_comb begin
    h0       = 36'($signed(vm_rd_data.rpos));
    len_fx   = $signed({3'b0, vm_rd_data.take_len, 16'b0});
    start_fx = $signed({4'b0, play_start, 16'b0});
    wrap_hi  = h0 > (len_fx - 36'sd65536);
    wrap_lo  = h0 < start_fx;
    if (wrap_hi) begin
      h1 = start_fx;
    end else if (wrap_lo) begin
      h1 = len_fx - 36'sd196608;
    end else begin
      h1 = h0;
    end
    idx   = h1[35:16];
    idx_b = idx + 20'sd1;
    len_s = $signed({3'b0, vm_rd_data.take_len});
    h_new = h1[33:0] + 34'(play_speed);
    start34 = {2'b0, play_start, 16'b0};
    play_nv = vm_rd_data;
    play_nv.rpos = h_new;
    if (wrap_hi && vm_rd_data.once_mode) begin
      play_nv.playing = 1'b0;
    end
  end

  // Recording update of the voice just read.
  always_comb begin
    rec_nv = vm_rd_data;
    wp1 = vm_rd_data.wpos + 17'd1;
    rec_nv.wpos = wp1;
    if (wp1 >= DEPTH_P) begin
      rec_nv.recording = 1'b0;
      rec_nv.take_len  = wp1;
      rec_nv.has_take  = 1'b1;
    end
  end

  // Request update of the addressed voice.
  always_comb begin
    req_nv = vm_rd_data;
    case (req_q)
      mvsr_pkg::REQ_START_REC: begin
        if (!vm_rd_data.recording) begin
          req_nv = mvsr_pkg::VOICE_RESET;
          req_nv.recording = 1'b1;
        end
      end
      mvsr_pkg::REQ_STOP_REC: begin
        if (vm_rd_data.recording) begin
          req_nv.recording = 1'b0;
          req_nv.take_len  = vm_rd_data.wpos;
          req_nv.has_take  = 1'b1;
        end
      end
      mvsr_pkg::REQ_START_PLAY: begin
        if (vm_rd_data.has_take) begin
          req_nv.once_mode  = once_q;
          req_nv.loop_mode  = loop_q;
          req_nv.rpos       = start34;
          req_nv.playing    = 1'b1;
          req_nv.fading_in  = 1'b1;
          req_nv.fading_out = 1'b0;
          req_nv.level      = '0;
        end
      end
      mvsr_pkg::REQ_STOP_PLAY: begin
        if (vm_rd_data.playing && !vm_rd_data.once_mode && !vm_rd_data.loop_mode) begin
          req_nv.fading_in  = 1'b0;
          req_nv.fading_out = 1'b1;
          req_nv.level      = mvsr_pkg::ENV_ONE;
        end
      end
      default: begin
        req_nv = vm_rd_data;
      end
    endcase
  end

  // Interpolation, gain and envelope arithmetic.
  always_comb begin
    b_val   = ok_b ? $signed(sm_rd_data) : 16'sd0;
    diff    = 17'(b_val) - 17'(a_q);
    sh      = prod_q >>> 16;
    interp  = 17'(a_q) + sh[16:0];
    x_g     = g_q[33:12];
    if (vs_q.fading_in || vs_q.fading_out) begin
      lvl_mul = $signed({2'b0, vs_q.level});
    end else begin
      lvl_mul = $signed({2'b0, mvsr_pkg::ENV_ONE});
    end
    voice_out = e_q[39:15];
    lvl_up  = {1'b0, vs_q.level} + {2'b0, envelope_step};
    lvl_dn  = $signed({2'b0, vs_q.level}) - $signed({3'b0, envelope_step});
  end

  // Envelope and stop conditions after one played sample.
  always_comb begin
    env_nv = vs_q;
    if (vs_q.fading_in) begin
      if (lvl_up >= 17'h08000) begin
        env_nv.level     = mvsr_pkg::ENV_ONE;
        env_nv.fading_in = 1'b0;
      end else begin
        env_nv.level = lvl_up[15:0];
      end
    end else if (vs_q.fading_out) begin
      if (lvl_dn <= 18'sd0) begin
        env_nv.level      = '0;
        env_nv.fading_out = 1'b0;
        env_nv.playing    = 1'b0;
      end else begin
        env_nv.level = lvl_dn[15:0];
      end
    end
    if (vs_q.rpos == start34 && vs_q.once_mode) begin
      env_nv.playing = 1'b0;
    end
  end

  // Memory port control.
  always_comb begin
    vm_rd_addr = (state == S_IDLE) ? VA_W'(in_ch.voice) : vidx;
    vm_wr_en   = 1'b0;
    vm_wr_addr = vidx;
    vm_wr_data = vs_q;
    sm_rd_addr = (state == S_RDB) ? addr_b : addr_a;
    sm_wr_en   = 1'b0;
    sm_wr_addr = base + SA_W'(vm_rd_data.wpos[15:0]);
    sm_wr_data = sample_q;
    unique case (state)
      S_EVAL: begin
        if (vm_rd_data.recording) begin
          vm_wr_en   = 1'b1;
          vm_wr_data = rec_nv;
          sm_wr_en   = vm_rd_data.wpos < DEPTH_P;
        end
      end
      S_WB: begin
        vm_wr_en = 1'b1;
      end
      S_REQ: begin
        vm_wr_en   = 1'b1;
        vm_wr_addr = VA_W'(voice_q);
        vm_wr_data = req_nv;
      end
      default: begin
        vm_wr_en = 1'b0;
      end
    endcase
  end

  // Result register: loaded when the item completes, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_load) begin
      out_valid <= 1'b1;
      out_rec   <= rep_rec;
      out_play  <= rep_play;
      if (mix_q > MIX_W'(32767)) begin
        out_mix <= 16'sh7FFF;
      end else if (mix_q < -MIX_W'(32768)) begin
        out_mix <= -16'sh8000;
      end else begin
        out_mix <= mix_q[15:0];
      end
    end else if (out_valid && out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_q    <= in_ch.req_type;
            voice_q  <= in_ch.voice;
            sample_q <= in_ch.in_sample;
            once_q   <= in_ch.play_once;
            loop_q   <= in_ch.play_loop;
            vvalid_q <= in_vvalid;
            vidx     <= '0;
            mix_q    <= '0;
            rep_rec  <= 1'b0;
            rep_play <= 1'b0;
            if (in_ch.req_type == mvsr_pkg::REQ_TICK) begin
              state <= S_ISSUE;
            end else if (in_vvalid) begin
              // Unknown requests pass through unchanged but still report the voice.
              state <= S_REQ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_ISSUE: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (!vm_rd_data.recording && vm_rd_data.playing && vm_rd_data.has_take) begin
            vs_q   <= play_nv;
            addr_a <= base + SA_W'(idx[15:0]);
            addr_b <= base + SA_W'(idx_b[15:0]);
            ok_a   <= !idx[19] && (idx < len_s);
            ok_b   <= !idx_b[19] && (idx_b < len_s);
            frac_q <= h1[15:0];
            state  <= S_RDA;
          end else begin
            if (is_mine) begin
              rep_rec  <= vm_rd_data.recording ? rec_nv.recording : 1'b0;
              rep_play <= vm_rd_data.playing;
            end
            if (vidx == LAST_VOICE) begin
              state <= S_DONE;
            end else begin
              vidx  <= vidx + 1'b1;
              state <= S_ISSUE;
            end
          end
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          a_q   <= ok_a ? $signed(sm_rd_data) : 16'sd0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod_q <= diff * $signed({1'b0, frac_q});
          state  <= S_GAIN;
        end
        S_GAIN: begin
          g_q   <= interp * $signed({1'b0, gain});
          state <= S_ENV;
        end
        S_ENV: begin
          e_q   <= x_g * lvl_mul;
          vs_q  <= env_nv;
          state <= S_WB;
        end
        S_WB: begin
          mix_q <= mix_q + MIX_W'(voice_out);
          if (is_mine) begin
            rep_rec  <= vs_q.recording;
            rep_play <= vs_q.playing;
          end
          if (vidx == LAST_VOICE) begin
            state <= S_DONE;
          end else begin
            vidx  <= vidx + 1'b1;
            state <= S_ISSUE;
          end
        end
        S_REQ: begin
          rep_rec  <= req_nv.recording;
          rep_play <= req_nv.playing;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (done_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/multi_voice_sample_recorder_player.sv
// A sample tick walks the voices through the state memory: each takes the
// issue and evaluate states, and a playing voice also the two frame reads on
// the sample memory port and the multiply, gain, envelope and write-back
// states. One item is in work at a time; the next is accepted while the
// previous result waits in the output register. Reset is synchronous:
// voice state reads as cleared at once, samples stay.
// ----------------------------------------------------------------------------
// multi_voice_sample_recorder_player
// Multi-voice sampler top level: configuration registers, memories, engine.
// ----------------------------------------------------------------------------
module multi_voice_sample_recorder_player #(
  parameter int VOICES = 32,
  parameter int BUFFER_DEPTH = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mvsr_req_if.sink                             in_ch,
  mvsr_rsp_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [mvsr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [mvsr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int VA_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SA_W = $clog2(VOICES * BUFFER_DEPTH);

  logic signed [mvsr_pkg::SPEED_W-1:0] play_speed;
  logic [mvsr_pkg::GAIN_W-1:0]         gain;
  logic [mvsr_pkg::STEP_W-1:0]         envelope_step;
  logic [mvsr_pkg::START_W-1:0]        play_start;

  logic [VA_W-1:0]             vm_rd_addr;
  mvsr_pkg::voice_t            vm_rd_data;
  logic                        vm_wr_en;
  logic [VA_W-1:0]             vm_wr_addr;
  mvsr_pkg::voice_t            vm_wr_data;
  logic [SA_W-1:0]             sm_rd_addr;
  logic [mvsr_pkg::SMP_W-1:0]  sm_rd_data;
  logic                        sm_wr_en;
  logic [SA_W-1:0]             sm_wr_addr;
  logic [mvsr_pkg::SMP_W-1:0]  sm_wr_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      play_speed    <= 20'sh10000;
      gain          <= 16'd4096;
      envelope_step <= 15'd64;
      play_start    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mvsr_pkg::CFG_PLAY_SPEED:    play_speed    <= $signed(cfg_data);
        mvsr_pkg::CFG_GAIN:          gain          <= cfg_data[15:0];
        mvsr_pkg::CFG_ENVELOPE_STEP: envelope_step <= cfg_data[14:0];
        mvsr_pkg::CFG_PLAY_START:    play_start    <= cfg_data[15:0];
        default: begin
          play_start <= play_start;
        end
      endcase
    end
  end

  mvsr_voice_mem #(.VOICES(VOICES)) u_voice_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (vm_rd_addr),
    .rd_data (vm_rd_data),
    .wr_en   (vm_wr_en),
    .wr_addr (vm_wr_addr),
    .wr_data (vm_wr_data)
  );

  mvsr_sample_mem #(.DEPTH(VOICES * BUFFER_DEPTH)) u_sample_mem (
    .clk     (clk),
    .rd_addr (sm_rd_addr),
    .rd_data (sm_rd_data),
    .wr_en   (sm_wr_en),
    .wr_addr (sm_wr_addr),
    .wr_data (sm_wr_data)
  );

  mvsr_engine #(.VOICES(VOICES), .BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .play_speed    (play_speed),
    .gain          (gain),
    .envelope_step (envelope_step),
    .play_start    (play_start),
    .vm_rd_addr    (vm_rd_addr),
    .vm_rd_data    (vm_rd_data),
    .vm_wr_en      (vm_wr_en),
    .vm_wr_addr    (vm_wr_addr),
    .vm_wr_data    (vm_wr_data),
    .sm_rd_addr    (sm_rd_addr),
    .sm_rd_data    (sm_rd_data),
    .sm_wr_en      (sm_wr_en),
    .sm_wr_addr    (sm_wr_addr),
    .sm_wr_data    (sm_wr_data)
  );

endmodule

// File: src/mvsr_checker.sv
// ----------------------------------------------------------------------------
// mvsr_checker
// Port-level checks of the sampler, bound to the top level.
// ----------------------------------------------------------------------------
module mvsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_mix,
  input logic        out_rec,
  input logic        out_play
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // One item at a time: an accepted transaction closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input open right after a transaction");

  // A voice never records and plays at once.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_rec && out_play))
    else $error("voice reported recording and playing");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mix))
    else $error("stalled result changed");

endmodule

bind multi_voice_sample_recorder_player mvsr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mix   (out_ch.mix_sample),
  .out_rec   (out_ch.voice_recording),
  .out_play  (out_ch.voice_playing)
);
